/* sv/esld_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esld_pkg
// Shared types and constants of the edge side link deduplicator.
// ----------------------------------------------------------------------------
package esld_pkg;

  localparam int EDGE_W   = 32;
  localparam int ID_W     = 44;
  localparam int COUNTY_W = 10;
  localparam int TRACT_W  = 20;
  localparam int BLOCK_W  = 14;
  localparam int ACC_W    = 30;

  // area field limits and decimal place weights
  localparam logic [COUNTY_W-1:0] COUNTY_MAX = 10'd999;
  localparam logic [TRACT_W-1:0]  TRACT_MAX  = 20'd999999;
  localparam logic [BLOCK_W-1:0]  BLOCK_MAX  = 14'd9999;
  localparam logic [TRACT_W-1:0]  TRACT_MUL  = 20'd1000000;
  localparam logic [BLOCK_W-1:0]  BLOCK_MUL  = 14'd10000;

  // hash unit dividend width
  localparam int DIV_W = 48;

  typedef enum logic [2:0] {
    OUT_NEW    = 3'd0,
    OUT_DUP    = 3'd1,
    OUT_SAME   = 3'd2,
    OUT_STORED = 3'd3,
    OUT_WEIRD  = 3'd4,
    OUT_NONE   = 3'd5,
    OUT_LFULL  = 3'd6,
    OUT_HFULL  = 3'd7
  } outcome_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PACK1,
    S_PACK2,
    S_DECIDE,
    S_HMOD,
    S_HREAD,
    S_HCHK,
    S_LMOD,
    S_LREAD,
    S_LCHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [EDGE_W-1:0]   edge_id;
    logic                left_present;
    logic [COUNTY_W-1:0] left_county;
    logic [TRACT_W-1:0]  left_tract;
    logic [BLOCK_W-1:0]  left_block;
    logic                right_present;
    logic [COUNTY_W-1:0] right_county;
    logic [TRACT_W-1:0]  right_tract;
    logic [BLOCK_W-1:0]  right_block;
  } in_item_t;

  typedef struct packed {
    outcome_t          outcome;
    logic [ID_W-1:0]   link_low;
    logic [ID_W-1:0]   link_high;
    logic [EDGE_W-1:0] edge_echo;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
  } link_ent_t;

  typedef struct packed {
    logic              valid;
    logic [EDGE_W-1:0] edge_id;
    logic [ID_W-1:0]   id;
  } half_ent_t;

endpackage

/* sv/esld_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esld_stream_if
// Valid/ready channel carrying one word of payload type T.
// ----------------------------------------------------------------------------
interface esld_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/esld_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esld_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module esld_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/esld_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esld_mod
// Remainder of a wide dividend by the power-of-two table depth DEPTH:
// the low address bits, registered with done in the cycle after start.
// ----------------------------------------------------------------------------
module esld_mod
  import esld_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIV_W-1:0]         dividend,
  output logic                     done,
  output logic [$clog2(DEPTH)-1:0] rem
);
  localparam int AW = $clog2(DEPTH);

  // keep the low bits and flag them ready on the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    if (start) begin
      rem <= dividend[AW-1:0];
    end
  end
endmodule

/* sv/edge_side_link_deduplicator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_side_link_deduplicator
// Packs edge side area codes into block ids, pairs halves by edge id in a
// hashed half table and keeps a deduplicated set of block links in a hashed link table.
//
//   channel  | dir | word
//   ---------+-----+--------------------------------------------
//   items    | in  | edge record (edge id, left and right areas)
//   results  | out | outcome, ordered link pair, edge id echo
//
// After reset a clearing pass writes max(LINK_DEPTH, HALF_DEPTH) entries,
// one per cycle, before the first word is taken. Both depths must be powers
// of two; the block does not enforce it. A table hash is its low address
// bits, registered in the cycle after start. One word at a time: it is taken
// in IDLE, packed in PACK1 and PACK2, decided in DECIDE and output in DONE;
// each probed table adds a hash state and, per slot up to PROBE_LIMIT, a
// RAM read and a check state; a one-sided record that completes a link
// probes both tables. A waiting result stalls only the DONE state; the next
// word is taken while it waits.
// ----------------------------------------------------------------------------
module edge_side_link_deduplicator
  import esld_pkg::*;
#(
  parameter int LINK_DEPTH  = 4096,
  parameter int HALF_DEPTH  = 4096,
  parameter int PROBE_LIMIT = 8
) (
  input  logic          clk,
  input  logic          rst,
  esld_stream_if.sink   items,
  esld_stream_if.source results
);
  localparam int LAW  = $clog2(LINK_DEPTH);
  localparam int HAW  = $clog2(HALF_DEPTH);
  localparam int MAXD = (LINK_DEPTH > HALF_DEPTH) ? LINK_DEPTH : HALF_DEPTH;
  localparam int CW   = $clog2(MAXD);
  localparam int IW   = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int LW   = $bits(link_ent_t);
  localparam int HW   = $bits(half_ent_t);

  state_t state, state_next;

  in_item_t            rec;
  logic [ACC_W-1:0]    l_acc, r_acc;
  logic [ID_W-1:0]     lid, rid, hid, lo, hi;
  logic [LAW-1:0]      k_l, free_kl;
  logic [HAW-1:0]      k_h, free_kh;
  logic [IW-1:0]       idx;
  logic                free_found;
  logic [CW-1:0]       clr_cnt;
  outcome_t            oc, oc_val;
  logic                oc_load;
  logic                res_valid;
  out_item_t           res_data;

  // RAM ports
  logic            lwe, hwe;
  logic [LAW-1:0]  laddr;
  logic [HAW-1:0]  haddr;
  link_ent_t       lwdata, lq;
  half_ent_t       hwdata, hq;
  logic [LW-1:0]   l_rdata;
  logic [HW-1:0]   h_rdata;

  // hash units
  logic             lmod_start, hmod_start, lmod_done, hmod_done;
  logic [DIV_W-1:0] lmod_div;
  logic [LAW-1:0]   lrem;
  logic [HAW-1:0]   hrem;

  // pair selection for a link try
  logic [ID_W-1:0] pa, pb, pmin, pmax;
  logic            set_pair;

  // probe status
  logic           l_match, l_fnow, h_match, h_fnow, last;
  logic [LAW-1:0] l_fk, k_l_inc;
  logic [HAW-1:0] h_fk, k_h_inc;
  logic           out_take;

  assign lq = l_rdata;
  assign hq = h_rdata;

  esld_ram #(.W(LW), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk(clk), .we(lwe), .waddr(laddr), .wdata(lwdata),
    .raddr(k_l), .rdata(l_rdata)
  );

  esld_ram #(.W(HW), .DEPTH(HALF_DEPTH)) u_half_ram (
    .clk(clk), .we(hwe), .waddr(haddr), .wdata(hwdata),
    .raddr(k_h), .rdata(h_rdata)
  );

  esld_mod #(.DEPTH(LINK_DEPTH)) u_link_mod (
    .clk(clk), .rst(rst), .start(lmod_start), .dividend(lmod_div),
    .done(lmod_done), .rem(lrem)
  );

  esld_mod #(.DEPTH(HALF_DEPTH)) u_half_mod (
    .clk(clk), .rst(rst), .start(hmod_start),
    .dividend(DIV_W'(rec.edge_id)), .done(hmod_done), .rem(hrem)
  );

  // probe window status
  assign last    = (idx == IW'(PROBE_LIMIT - 1));
  assign l_match = lq.valid && (lq.lo == lo) && (lq.hi == hi);
  assign l_fnow  = free_found || !lq.valid;
  assign l_fk    = free_found ? free_kl : k_l;
  assign k_l_inc = (k_l == LAW'(LINK_DEPTH - 1)) ? '0 : k_l + 1'b1;
  assign h_match = hq.valid && (hq.edge_id == rec.edge_id);
  assign h_fnow  = free_found || !hq.valid;
  assign h_fk    = free_found ? free_kh : k_h;
  assign k_h_inc = (k_h == HAW'(HALF_DEPTH - 1)) ? '0 : k_h + 1'b1;

  // link operands: both sides, or the incoming half and the stored one
  assign pa       = (state == S_HCHK) ? hid : lid;
  assign pb       = (state == S_HCHK) ? hq.id : rid;
  assign pmin     = (pa < pb) ? pa : pb;
  assign pmax     = (pa < pb) ? pb : pa;
  assign lmod_div = DIV_W'(pa) + DIV_W'(pb);

  assign out_take      = !res_valid || results.ready;
  assign items.ready   = (state == S_IDLE);
  assign results.valid = res_valid;
  assign results.data  = res_data;

  // next state, RAM writes and unit starts
  always_comb begin
    state_next = state;
    lmod_start = 1'b0;
    hmod_start = 1'b0;
    set_pair   = 1'b0;
    lwe        = 1'b0;
    laddr      = k_l;
    lwdata     = '0;
    hwe        = 1'b0;
    haddr      = k_h;
    hwdata     = '0;
    oc_load    = 1'b0;
    oc_val     = OUT_NONE;
    unique case (state)
      S_CLEAR: begin
        lwe   = ({1'b0, clr_cnt} < (CW+1)'(LINK_DEPTH));
        hwe   = ({1'b0, clr_cnt} < (CW+1)'(HALF_DEPTH));
        laddr = clr_cnt[LAW-1:0];
        haddr = clr_cnt[HAW-1:0];
        if (clr_cnt == CW'(MAXD - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (items.valid) begin
          state_next = S_PACK1;
        end
      end
      S_PACK1: state_next = S_PACK2;
      S_PACK2: state_next = S_DECIDE;
      S_DECIDE: begin
        if (!rec.left_present && !rec.right_present) begin
          oc_load = 1'b1; oc_val = OUT_NONE; state_next = S_DONE;
        end else if (rec.left_present && rec.right_present) begin
          if (lid == rid) begin
            oc_load = 1'b1; oc_val = OUT_SAME; state_next = S_DONE;
          end else begin
            lmod_start = 1'b1; set_pair = 1'b1; state_next = S_LMOD;
          end
        end else begin
          hmod_start = 1'b1; state_next = S_HMOD;
        end
      end
      S_HMOD: begin
        if (hmod_done) begin
          state_next = S_HREAD;
        end
      end
      S_HREAD: state_next = S_HCHK;
      S_HCHK: begin
        if (h_match) begin
          // drop the stored half, then weird split or link try
          hwe = 1'b1;
          if (hq.id == hid) begin
            oc_load = 1'b1; oc_val = OUT_WEIRD; state_next = S_DONE;
          end else begin
            lmod_start = 1'b1; set_pair = 1'b1; state_next = S_LMOD;
          end
        end else if (last) begin
          oc_load = 1'b1;
          if (h_fnow) begin
            hwe    = 1'b1;
            haddr  = h_fk;
            hwdata = '{valid: 1'b1, edge_id: rec.edge_id, id: hid};
            oc_val = OUT_STORED;
          end else begin
            oc_val = OUT_HFULL;
          end
          state_next = S_DONE;
        end else begin
          state_next = S_HREAD;
        end
      end
      S_LMOD: begin
        if (lmod_done) begin
          state_next = S_LREAD;
        end
      end
      S_LREAD: state_next = S_LCHK;
      S_LCHK: begin
        if (l_match) begin
          oc_load = 1'b1; oc_val = OUT_DUP; state_next = S_DONE;
        end else if (last) begin
          oc_load = 1'b1;
          if (l_fnow) begin
            lwe    = 1'b1;
            laddr  = l_fk;
            lwdata = '{valid: 1'b1, lo: lo, hi: hi};
            oc_val = OUT_NEW;
          end else begin
            oc_val = OUT_LFULL;
          end
          state_next = S_DONE;
        end else begin
          state_next = S_LREAD;
        end
      end
      S_DONE: begin
        if (out_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && items.valid) begin
      rec <= items.data;
    end
    // pack: county*10^6 + tract, then *10^4 + block, fields saturated
    if (state == S_PACK1) begin
      l_acc <= ACC_W'((rec.left_county > COUNTY_MAX) ? COUNTY_MAX : rec.left_county)
                 * ACC_W'(TRACT_MUL)
             + ACC_W'((rec.left_tract > TRACT_MAX) ? TRACT_MAX : rec.left_tract);
      r_acc <= ACC_W'((rec.right_county > COUNTY_MAX) ? COUNTY_MAX : rec.right_county)
                 * ACC_W'(TRACT_MUL)
             + ACC_W'((rec.right_tract > TRACT_MAX) ? TRACT_MAX : rec.right_tract);
    end
    if (state == S_PACK2) begin
      lid <= ID_W'(l_acc) * ID_W'(BLOCK_MUL)
           + ID_W'((rec.left_block > BLOCK_MAX) ? BLOCK_MAX : rec.left_block);
      rid <= ID_W'(r_acc) * ID_W'(BLOCK_MUL)
           + ID_W'((rec.right_block > BLOCK_MAX) ? BLOCK_MAX : rec.right_block);
    end
    if (state == S_DECIDE) begin
      hid <= rec.left_present ? lid : rid;
    end
    if (set_pair) begin
      lo <= pmin;
      hi <= pmax;
    end
    if (oc_load) begin
      oc <= oc_val;
    end
    // open a probe window
    if (state == S_HMOD && hmod_done) begin
      k_h        <= hrem;
      idx        <= '0;
      free_found <= 1'b0;
    end
    if (state == S_LMOD && lmod_done) begin
      k_l        <= lrem;
      idx        <= '0;
      free_found <= 1'b0;
    end
    // advance a probe, remember the first free slot
    if (state == S_HCHK && !h_match && !last) begin
      k_h        <= k_h_inc;
      idx        <= idx + 1'b1;
      free_found <= h_fnow;
      free_kh    <= h_fk;
    end
    if (state == S_LCHK && !l_match && !last) begin
      k_l        <= k_l_inc;
      idx        <= idx + 1'b1;
      free_found <= l_fnow;
      free_kl    <= l_fk;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && out_take) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_take) begin
      res_data.outcome   <= oc;
      res_data.link_low  <= (oc == OUT_NEW || oc == OUT_DUP) ? lo : '0;
      res_data.link_high <= (oc == OUT_NEW || oc == OUT_DUP) ? hi : '0;
      res_data.edge_echo <= rec.edge_id;
    end
  end
endmodule

/* sv/esld_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esld_checker
// Port-level checks of the edge side link deduplicator, bound to the top.
// ----------------------------------------------------------------------------
module esld_checker
  import esld_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [2:0]            outcome,
  input logic [ID_W-1:0]       link_low,
  input logic [ID_W-1:0]       link_high
);
  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({outcome, link_low, link_high}))
    else $error("stalled result changed");

  // one record at a time: busy after a word is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // link fields are zero unless a link is reported
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome != OUT_NEW && outcome != OUT_DUP
      |-> link_low == '0 && link_high == '0)
    else $error("link fields set without link");

  // a reported link is ordered and proper
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OUT_NEW || outcome == OUT_DUP) |-> link_low < link_high)
    else $error("link pair out of order");
endmodule

bind edge_side_link_deduplicator esld_checker u_esld_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .outcome   (results.data.outcome),
  .link_low  (results.data.link_low),
  .link_high (results.data.link_high)
);

/* test/tb_edge_side_link_deduplicator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_side_link_deduplicator
// Self-checking bench for the edge side link deduplicator. Drives edge
// records with random idle and stall bursts, predicts each result word from
// its own copy of the link and half tables, and compares field by field.
// ----------------------------------------------------------------------------
module tb_edge_side_link_deduplicator;
  import esld_pkg::*;

  localparam int LDEPTH = 4096;
  localparam int HDEPTH = 4096;
  localparam int PROBES = 8;
  localparam int N_RANDOM = 950;
  localparam int CYCLE_LIMIT = 400000;

  // scoreboard holding a model of both tables and the expected words
  class link_scoreboard;
    link_ent_t links [LDEPTH];
    half_ent_t halves [HDEPTH];
    out_item_t pending [$];
    int errors;
    int n_checked;
    int outcome_seen [8];

    function new();
      foreach (links[i]) links[i] = '0;
      foreach (halves[i]) halves[i] = '0;
      errors = 0;
      n_checked = 0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
    endfunction

    function logic [ID_W-1:0] block_id(logic [COUNTY_W-1:0] c, logic [TRACT_W-1:0] t,
                                       logic [BLOCK_W-1:0] b);
      longint unsigned cc, tt, bb;
      cc = (c > 999) ? 999 : c;
      tt = (t > 999999) ? 999999 : t;
      bb = (b > 9999) ? 9999 : b;
      return ID_W'((cc * 1000000 + tt) * 10000 + bb);
    endfunction

    function outcome_t insert_link(logic [ID_W-1:0] a, logic [ID_W-1:0] b,
                                   output logic [ID_W-1:0] lo, output logic [ID_W-1:0] hi);
      longint unsigned base;
      int slot, k;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      base = (longint'(lo) + longint'(hi)) % LDEPTH;
      slot = -1;
      for (int i = 0; i < PROBES; i++) begin
        k = int'((base + i) % LDEPTH);
        if (links[k].valid) begin
          if (links[k].lo == lo && links[k].hi == hi) return OUT_DUP;
        end else if (slot < 0) slot = k;
      end
      if (slot < 0) return OUT_LFULL;
      links[slot] = '{valid: 1'b1, lo: lo, hi: hi};
      return OUT_NEW;
    endfunction

    function outcome_t match_half(logic [ID_W-1:0] id, logic [EDGE_W-1:0] e,
                                  output logic [ID_W-1:0] lo, output logic [ID_W-1:0] hi);
      int base, slot, k;
      logic [ID_W-1:0] other;
      lo = '0;
      hi = '0;
      base = int'(e % HDEPTH);
      slot = -1;
      for (int i = 0; i < PROBES; i++) begin
        k = (base + i) % HDEPTH;
        if (halves[k].valid) begin
          if (halves[k].edge_id == e) begin
            other = halves[k].id;
            halves[k].valid = 1'b0;
            if (other == id) return OUT_WEIRD;
            return insert_link(id, other, lo, hi);
          end
        end else if (slot < 0) slot = k;
      end
      if (slot < 0) return OUT_HFULL;
      halves[slot] = '{valid: 1'b1, edge_id: e, id: id};
      return OUT_STORED;
    endfunction

    // note an accepted record and queue its expected word
    function void note_record(in_item_t r);
      out_item_t w;
      logic [ID_W-1:0] lid, rid, lo, hi;
      outcome_t oc;
      lid = block_id(r.left_county, r.left_tract, r.left_block);
      rid = block_id(r.right_county, r.right_tract, r.right_block);
      lo = '0;
      hi = '0;
      if (!r.left_present && !r.right_present) oc = OUT_NONE;
      else if (!r.left_present) oc = match_half(rid, r.edge_id, lo, hi);
      else if (!r.right_present) oc = match_half(lid, r.edge_id, lo, hi);
      else if (lid == rid) oc = OUT_SAME;
      else oc = insert_link(lid, rid, lo, hi);
      if (oc != OUT_NEW && oc != OUT_DUP) begin
        lo = '0;
        hi = '0;
      end
      w.outcome = oc;
      w.link_low = lo;
      w.link_high = hi;
      w.edge_echo = r.edge_id;
      pending.push_back(w);
    endfunction

    // compare a result word with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      n_checked++;
      outcome_seen[exp_w.outcome]++;
      if (got.outcome !== exp_w.outcome) begin
        $display("%0t: outcome expected %0d actual %0d", $time, exp_w.outcome, got.outcome);
        errors++;
      end
      if (got.link_low !== exp_w.link_low) begin
        $display("%0t: link_low expected %0d actual %0d", $time, exp_w.link_low, got.link_low);
        errors++;
      end
      if (got.link_high !== exp_w.link_high) begin
        $display("%0t: link_high expected %0d actual %0d", $time, exp_w.link_high,
                 got.link_high);
        errors++;
      end
      if (got.edge_echo !== exp_w.edge_echo) begin
        $display("%0t: edge_echo expected %0h actual %0h", $time, exp_w.edge_echo,
                 got.edge_echo);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int cycles;
  bit calm;
  int n_sent;
  link_scoreboard board;

  esld_stream_if #(.T(in_item_t)) items ();
  esld_stream_if #(.T(out_item_t)) results ();

  edge_side_link_deduplicator DUT (
    .clk(clk),
    .rst(rst),
    .items(items.sink),
    .results(results.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // check accepted result words; stall the result side in bursts
  initial begin
    int stall;
    results.ready <= 1'b0;
    stall = 0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (!rst && results.valid && results.ready) board.check_result(results.data);
      if (stall > 0) begin
        stall--;
        results.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9) - 1;
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // drive one record and hold it until taken; valid stays up between words unless a random gap drops it
  task automatic send_record(in_item_t r);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      items.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items.data <= r;
    items.valid <= 1'b1;
    do @(posedge clk); while (!items.ready);
    board.note_record(r);
    n_sent++;
  endtask

  function automatic in_item_t rand_record(logic [EDGE_W-1:0] e, bit lp, bit rp);
    in_item_t r;
    r = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom});
    r.edge_id = e;
    r.left_present = lp;
    r.right_present = rp;
    // keep most area codes in range, small pools so links repeat
    if ($urandom_range(0, 7) != 0) begin
      r.left_county = COUNTY_W'($urandom_range(0, 3));
      r.left_tract = TRACT_W'($urandom_range(0, 3));
      r.left_block = BLOCK_W'($urandom_range(0, 5));
      r.right_county = COUNTY_W'($urandom_range(0, 3));
      r.right_tract = TRACT_W'($urandom_range(0, 3));
      r.right_block = BLOCK_W'($urandom_range(0, 5));
    end
    return r;
  endfunction

  function automatic in_item_t area_record(logic [EDGE_W-1:0] e, bit lp, int lc, int lt,
                                           int lb, bit rp, int rc, int rt, int rb);
    in_item_t r;
    r.edge_id = e;
    r.left_present = lp;
    r.left_county = COUNTY_W'(lc);
    r.left_tract = TRACT_W'(lt);
    r.left_block = BLOCK_W'(lb);
    r.right_present = rp;
    r.right_county = COUNTY_W'(rc);
    r.right_tract = TRACT_W'(rt);
    r.right_block = BLOCK_W'(rb);
    return r;
  endfunction

  initial begin
    in_item_t r;
    logic [EDGE_W-1:0] e;
    int pool_base;
    board = new();
    cycles = 0;
    calm = 0;
    n_sent = 0;
    rst <= 1'b1;
    items.valid <= 1'b0;
    items.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: no sides, same block, new and duplicate link, saturation
    send_record(area_record(32'h0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_record(area_record(32'hFFFFFFFF, 1, 999, 999999, 9999, 1, 999, 999999, 9999));
    send_record(area_record(32'd1, 1, 0, 0, 0, 1, 999, 999999, 9999));
    send_record(area_record(32'd2, 1, 999, 999999, 9999, 1, 0, 0, 0));
    send_record(area_record(32'd3, 1, 1023, 1048575, 16383, 1, 5, 6, 7));
    send_record(area_record(32'd4, 1, 999, 999999, 9999, 1, 1023, 1048575, 16383));
    // halves: store, complete a link, weird split, duplicate by halves
    send_record(area_record(32'd10, 1, 5, 6, 7, 0, 0, 0, 0));
    send_record(area_record(32'd10, 0, 0, 0, 0, 1, 8, 9, 10));
    send_record(area_record(32'd11, 0, 0, 0, 0, 1, 8, 9, 10));
    send_record(area_record(32'd11, 1, 8, 9, 10, 0, 0, 0, 0));
    send_record(area_record(32'd12, 1, 8, 9, 10, 0, 0, 0, 0));
    send_record(area_record(32'd12, 0, 0, 0, 0, 1, 5, 6, 7));
    // fill one half window, then overflow it
    for (int i = 0; i < PROBES + 1; i++)
      send_record(area_record(32'd100 + i * HDEPTH, 1, 1, 1, i, 0, 0, 0, 0));
    // fill one link window (sum 2*base) then overflow it
    for (int i = 0; i < PROBES + 1; i++)
      send_record(area_record(32'd200 + i, 1, 0, 0, 50 - i, 1, 0, 0, 50 + i + 4096));
    // a half that matches but finds its link window full
    send_record(area_record(32'd300, 1, 0, 0, 41, 0, 0, 0, 0));
    send_record(area_record(32'd300, 0, 0, 0, 0, 1, 0, 0, 4155));

    // random: mostly paired halves sharing edge ids, plus full links and noise
    pool_base = $urandom;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 120) calm = 1;
      e = pool_base + $urandom_range(0, 40);
      if ($urandom_range(0, 15) == 0) e = $urandom;
      case ($urandom_range(0, 9))
        0: r = rand_record(e, 0, 0);
        1, 2, 3: r = rand_record(e, 1, 1);
        4, 5, 6: r = rand_record(e, 1, 0);
        default: r = rand_record(e, 0, 1);
      endcase
      send_record(r);
    end
    items.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d records, checked %0d results", n_sent, board.n_checked);
    $display("outcomes new %0d dup %0d half %0d weird %0d lfull %0d hfull %0d",
             board.outcome_seen[OUT_NEW], board.outcome_seen[OUT_DUP],
             board.outcome_seen[OUT_STORED], board.outcome_seen[OUT_WEIRD],
             board.outcome_seen[OUT_LFULL], board.outcome_seen[OUT_HFULL]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/esld_pkg.sv
sv/esld_stream_if.sv
sv/esld_ram.sv
sv/esld_mod.sv
sv/edge_side_link_deduplicator.sv
sv/esld_checker.sv
test/tb_edge_side_link_deduplicator.sv
